>>> sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: sizing of the ring
// store, operation and status codes, and the input and result beat layouts.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_PEEK_FRONT = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [DATA_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic                     now_empty;
  } out_item_t;

endpackage

>>> sv/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values kept in a ring store in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; the beat is taken on a rising edge with
//   start high and busy low. busy stays low, so a new beat may be offered
//   every cycle.
//   Operations: push front, push back, pop front, pop back, peek front.
//   Every beat yields one result beat on out_result, marked by out_valid for
//   exactly one cycle, in the cycle right after the input beat was taken.
//   Valid and status are registered in the core, read data by the registered
//   read port of the store RAM; throughput is one operation per cycle, since
//   each operation touches at most one end pointer and at most one store entry.
//   A push on a full deque reports overflow and drops the value; a pop or
//   peek on an empty deque reports underflow. read_value is zero except for
//   a successful pop or peek.
//   Reset (rst_n low, synchronous) empties the deque: pointers and fill count
//   clear, store contents are left as they are and never read before written.
//   The receiver cannot stall; a result is gone after its single cycle.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_result
);

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic [1:0]       status_r, status_nxt;
  logic             use_rd_r, use_rd_nxt;

  logic             accept;
  logic             full;
  logic             empty;
  logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  logic [DATA_W-1:0] rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign tail_inc = (tail_r == IDX_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? IDX_W'(DEPTH - 1) : tail_r - 1'b1;

  // Decode the operation: pointer moves, store access and status.
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    use_rd_nxt = 1'b0;
    we         = 1'b0;
    waddr      = tail_r;
    raddr      = head_r;
    if (accept) begin
      unique case (in_item.func)
        FUNC_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_OVER;
          end else begin
            head_nxt  = head_dec;
            waddr     = head_dec;
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        FUNC_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_OVER;
          end else begin
            tail_nxt  = tail_inc;
            waddr     = tail_r;
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        FUNC_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_UNDER;
          end else begin
            raddr      = head_r;
            use_rd_nxt = 1'b1;
            head_nxt   = head_inc;
            count_nxt  = count_r - 1'b1;
          end
        end
        FUNC_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_UNDER;
          end else begin
            raddr      = tail_dec;
            use_rd_nxt = 1'b1;
            tail_nxt   = tail_dec;
            count_nxt  = count_r - 1'b1;
          end
        end
        FUNC_PEEK_FRONT: begin
          if (empty) begin
            status_nxt = ST_UNDER;
          end else begin
            raddr      = head_r;
            use_rd_nxt = 1'b1;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      use_rd_r    <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= accept;
      use_rd_r    <= use_rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_item.item_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Count already reflects the operation when its result beat is shown.
  assign out_valid             = out_valid_r;
  assign out_result.read_value = use_rd_r ? rdata : '0;
  assign out_result.status     = out_valid_r ? status_r : ST_OK;
  assign out_result.now_empty  = (count_r == '0);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count exceeds depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result beat without an input beat");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.status == ST_OVER) |-> $past(count_r) == CNT_W'(DEPTH))
    else $error("overflow reported on a deque that was not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.status == ST_UNDER) |-> $past(count_r) == '0)
    else $error("underflow reported on a deque that was not empty");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives push, pop and peek beats into the ring-store deque, covers the
// empty and full boundaries, index wrap at both ends and unused function
// codes. Keeps a mirror of the deque to predict each result beat and compares
// every result field against it.
// ----------------------------------------------------------------------------
module testbench;
  import deq_pkg::*;

  localparam int         CLK_HALF      = 5;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         IDLE_PCT      = 17;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         MODE_SPAN     = 32;
  localparam logic [2:0] FUNC_RSVD_LO  = 3'd5;
  localparam logic [2:0] FUNC_RSVD_HI  = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} walk_mode_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_result;

  double_ended_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  always #CLK_HALF clk = ~clk;

  // Mirror of the deque contents and pointers.
  logic signed [DATA_W-1:0] mirror_store [DEPTH];
  logic [IDX_W-1:0]         mirror_head = '0;
  logic [IDX_W-1:0]         mirror_tail = '0;
  logic [CNT_W-1:0]         mirror_fill = '0;

  out_item_t pending_results[$];
  int        error_count     = 0;
  int        results_checked = 0;
  int        underflow_seen  = 0;
  int        overflow_seen   = 0;
  int        full_hits       = 0;
  int        func_seen [8];
  bit        gaps_on         = 1'b1;

  function automatic logic [IDX_W-1:0] ring_fwd(logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_back(logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic out_item_t deque_apply(logic [2:0] func, logic signed [DATA_W-1:0] val);
    out_item_t res;
    logic      full;
    logic      empty;
    res        = '0;
    res.status = ST_OK;
    full       = (mirror_fill == CNT_W'(DEPTH));
    empty      = (mirror_fill == '0);
    case (func)
      FUNC_PUSH_FRONT: begin
        if (full) begin
          res.status = ST_OVER;
        end else begin
          mirror_head               = ring_back(mirror_head);
          mirror_store[mirror_head] = val;
          mirror_fill++;
        end
      end
      FUNC_PUSH_BACK: begin
        if (full) begin
          res.status = ST_OVER;
        end else begin
          mirror_store[mirror_tail] = val;
          mirror_tail               = ring_fwd(mirror_tail);
          mirror_fill++;
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) begin
          res.status = ST_UNDER;
        end else begin
          res.read_value = mirror_store[mirror_head];
          mirror_head    = ring_fwd(mirror_head);
          mirror_fill--;
        end
      end
      FUNC_POP_BACK: begin
        if (empty) begin
          res.status = ST_UNDER;
        end else begin
          mirror_tail    = ring_back(mirror_tail);
          res.read_value = mirror_store[mirror_tail];
          mirror_fill--;
        end
      end
      FUNC_PEEK_FRONT: begin
        if (empty) begin
          res.status = ST_UNDER;
        end else begin
          res.read_value = mirror_store[mirror_head];
        end
      end
      default: ;
    endcase
    res.now_empty = (mirror_fill == '0);
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, field, got, want);
    error_count++;
  endtask

  // Result checker: the receiver cannot stall, so sample every strobed beat.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_result.read_value, '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_result.read_value !== want.read_value)
          report_mismatch("read_value", out_result.read_value, want.read_value);
        if (out_result.status !== want.status)
          report_mismatch("status", DATA_W'(out_result.status), DATA_W'(want.status));
        if (out_result.now_empty !== want.now_empty)
          report_mismatch("now_empty", DATA_W'(out_result.now_empty), DATA_W'(want.now_empty));
      end
    end
  end

  // Offer one beat; start stays high afterward so the next beat can follow.
  task automatic send_op(logic [2:0] func, logic signed [DATA_W-1:0] val);
    out_item_t res;
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      start   <= 1'b0;
      in_item <= {3'($urandom), 32'($urandom)};
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{func: func, item_value: val};
    @(posedge clk);
    while (busy) @(posedge clk);
    res = deque_apply(func, val);
    pending_results.push_back(res);
    func_seen[func]++;
    if (res.status == ST_UNDER) underflow_seen++;
    if (res.status == ST_OVER) overflow_seen++;
    if (mirror_fill == CNT_W'(DEPTH)) full_hits++;
  endtask

  // Hold off the sender until every expected beat has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_func(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 3'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI));
    if (r < 4 + push_pct) return $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
    if (r < 90) return $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
    return FUNC_PEEK_FRONT;
  endfunction

  task automatic test_empty_and_extremes();
    send_op(FUNC_POP_FRONT, 32'h1234_5678);
    send_op(FUNC_POP_BACK, '1);
    send_op(FUNC_PEEK_FRONT, '0);
    for (int c = FUNC_RSVD_LO; c <= FUNC_RSVD_HI; c++) send_op(3'(c), 32'h5555_5555);
    send_op(FUNC_PUSH_BACK, 32'h7fff_ffff);
    send_op(FUNC_PUSH_FRONT, 32'h8000_0000);
    send_op(FUNC_PUSH_BACK, '0);
    send_op(FUNC_PUSH_FRONT, '1);
    send_op(FUNC_PUSH_BACK, 32'haaaa_aaaa);
    send_op(FUNC_PEEK_FRONT, 32'h5555_5555);
    send_op(FUNC_RSVD_HI, 32'haaaa_aaaa);
    send_op(FUNC_POP_FRONT, '0);
    send_op(FUNC_POP_BACK, '0);
    send_op(FUNC_POP_FRONT, '0);
    send_op(FUNC_POP_BACK, '0);
    send_op(FUNC_PEEK_FRONT, '0);
    send_op(FUNC_POP_FRONT, '0);
    send_op(FUNC_POP_BACK, '0);
    drain_results();
  endtask

  // Walk both pointers past the end of the store in each direction.
  task automatic test_ring_wrap();
    for (int i = 0; i < DEPTH + 3; i++) begin
      send_op(FUNC_PUSH_BACK, random_value());
      send_op(FUNC_POP_FRONT, random_value());
    end
    for (int i = 0; i < DEPTH + 3; i++) begin
      send_op(FUNC_PUSH_FRONT, random_value());
      send_op(FUNC_POP_BACK, random_value());
    end
    drain_results();
  endtask

  task automatic test_full_boundary();
    for (int i = 0; i < DEPTH; i++)
      send_op(i[0] ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, random_value());
    send_op(FUNC_PUSH_BACK, 32'h7fff_ffff);
    send_op(FUNC_PUSH_FRONT, 32'h8000_0000);
    send_op(FUNC_PEEK_FRONT, '0);
    send_op(FUNC_RSVD_LO, '1);
    for (int i = 0; i < DEPTH; i++)
      send_op(i[0] ? FUNC_POP_BACK : FUNC_POP_FRONT, random_value());
    send_op(FUNC_POP_BACK, '0);
    drain_results();
  endtask

  task automatic test_random_walk(int count);
    walk_mode_t mode;
    int         push_pct;
    mode = MODE_MIXED;
    push_pct = 44;
    for (int i = 0; i < count; i++) begin
      if (i % MODE_SPAN == 0) begin
        mode = walk_mode_t'($urandom_range(0, 2));
        case (mode)
          MODE_FILL:  push_pct = 70;
          MODE_DRAIN: push_pct = 15;
          default:    push_pct = 44;
        endcase
      end
      send_op(pick_func(push_pct), random_value());
    end
    drain_results();
  endtask

  task automatic test_back_to_back(int count);
    gaps_on = 1'b0;
    test_random_walk(count);
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_extremes();
    test_ring_wrap();
    test_full_boundary();
    test_random_walk(520);
    test_back_to_back(200);
    drain_results();
    $display("summary: %0d result beats checked, %0d overflows, %0d underflows, full %0d times",
             results_checked, overflow_seen, underflow_seen, full_hits);
    $display("summary: push f/b %0d/%0d, pop f/b %0d/%0d, peek %0d, unused codes %0d",
             func_seen[FUNC_PUSH_FRONT], func_seen[FUNC_PUSH_BACK], func_seen[FUNC_POP_FRONT],
             func_seen[FUNC_POP_BACK], func_seen[FUNC_PEEK_FRONT],
             func_seen[5] + func_seen[6] + func_seen[7]);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("watchdog: cycle limit reached, %0d beats still pending", pending_results.size());
    $display("testbench: errors");
    $finish;
  end

endmodule
